>>> sv/scc_pkg.sv
package scc_pkg;

  localparam int NUM_SETS  = 4;
  localparam int NUM_RULES = 4;

  // least coverage percent for a rule set to be eligible
  localparam logic [6:0] MIN_COVERAGE = 7'd60;

  // comfortable climate window, tenths of a unit, inclusive
  localparam logic signed [11:0] COMFY_TEMP_LO = 12'sd180;
  localparam logic signed [11:0] COMFY_TEMP_HI = 12'sd300;
  localparam logic [9:0]         COMFY_HUM_LO  = 10'd300;
  localparam logic [9:0]         COMFY_HUM_HI  = 10'd750;

  localparam logic [2:0] MODE_DETECT      = 3'd0;
  localparam logic [2:0] MODE_STUDY       = 3'd1;
  localparam logic [2:0] MODE_REST        = 3'd2;
  localparam logic [2:0] MODE_VENTILATION = 3'd3;
  localparam logic [2:0] MODE_ENERGY      = 3'd4;
  localparam logic [2:0] MODE_CUSTOM      = 3'd5;

  localparam logic [1:0] VERDICT_POSSIBLE  = 2'd0;
  localparam logic [1:0] VERDICT_AMBIGUOUS = 2'd1;
  localparam logic [1:0] VERDICT_MISSING   = 2'd2;
  localparam logic [1:0] VERDICT_UNKNOWN   = 2'd3;

  localparam logic [2:0] REG_LIGHT_BRIGHT = 3'd0;
  localparam logic [2:0] REG_LIGHT_DIM    = 3'd1;
  localparam logic [2:0] REG_SOUND_STUDY  = 3'd2;
  localparam logic [2:0] REG_SOUND_QUIET  = 3'd3;
  localparam logic [2:0] REG_TEMP_HIGH    = 3'd4;
  localparam logic [2:0] REG_HUM_HIGH     = 3'd5;
  localparam logic [2:0] REG_MATCH_THR    = 3'd6;
  localparam logic [2:0] REG_AMBIG_GAP    = 3'd7;

  localparam logic [4:0] ABSENT_ALL = 5'b10000;

  // rule weights, index [set][rule]: study, rest, ventilation, energy
  localparam logic [2:0] RULE_W [NUM_SETS][NUM_RULES] = '{
    '{3'd3, 3'd2, 3'd3, 3'd1},
    '{3'd3, 3'd3, 3'd2, 3'd1},
    '{3'd3, 3'd3, 3'd2, 3'd0},
    '{3'd4, 3'd2, 3'd1, 3'd0}
  };

  // bit i: rule i exists in the set
  localparam logic [3:0] RULE_USED [NUM_SETS] = '{4'b1111, 4'b1111, 4'b0111, 4'b0111};

  // bit i: rule i is required for eligibility
  localparam logic [3:0] RULE_REQ [NUM_SETS] = '{4'b0101, 4'b0011, 4'b0011, 4'b0001};

  // total weight of each set
  localparam logic [3:0] SET_TOTAL [NUM_SETS] = '{4'd9, 4'd9, 4'd8, 4'd7};

  typedef logic [255:0][6:0] pct_tab_t;

  // entry {num, den}: round-half-up percent of num over den, zero for den 0
  function automatic pct_tab_t build_pct_tab();
    pct_tab_t tab;
    int lim;
    int q;
    tab = '0;
    for (int num = 0; num < 16; num++) begin
      for (int den = 1; den < 16; den++) begin
        lim = num * 100 + (den >> 1);
        q = 0;
        for (int k = 1; k <= 100; k++) begin
          if (k * den <= lim) q = k;
        end
        tab[num * 16 + den] = q[6:0];
      end
    end
    return tab;
  endfunction

  localparam pct_tab_t PCT_TAB = build_pct_tab();

endpackage

>>> sv/sensor_context_classifier.sv
// room context classifier: one sensor snapshot in, one classification out
//
// input channel: in_valid / in_stall with the snapshot fields (mode, five
// readings with their ok flags). a transaction happens on a rising edge with
// in_valid high and in_stall low. output channel: out_valid / out_stall with
// candidate, verdict, percentages and evidence masks, same rule.
//
// four register stages: rule compares, weight sums with percent lookup, set
// selection, verdict and output register. the first is loaded by the input
// transaction itself, and the item moves on through stages 2 and 3 to the output.
// throughput is one snapshot per cycle while in_stall is low; each stage is a
// register with its own valid bit, so bubbles close up and the block keeps
// taking input while a result waits in the output register.
//
// when out_stall is high the output holds and the stages behind it fill;
// in_stall rises only once every stage holds an item.
// reset (rst, synchronous) empties the pipeline and loads the threshold
// registers with their default values. thresholds are written through
// cfg_write / cfg_index / cfg_data and should change only while idle.
module sensor_context_classifier (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          selected_mode,
  input  logic                light_ok,
  input  logic [11:0]         light_raw,
  input  logic                sound_ok,
  input  logic [11:0]         sound_raw,
  input  logic                temp_ok,
  input  logic signed [11:0]  temp_tenths,
  input  logic                hum_ok,
  input  logic [9:0]          hum_tenths,
  input  logic                motion_ok,
  input  logic                motion_seen,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          candidate,
  output logic [1:0]          verdict,
  output logic [6:0]          coverage_pct,
  output logic [6:0]          match_pct,
  output logic [3:0]          support_bits,
  output logic [3:0]          oppose_bits,
  output logic [4:0]          absent_bits
);
  import scc_pkg::*;

  // threshold registers
  logic [11:0]        light_bright_level;
  logic [11:0]        light_dim_level;
  logic [11:0]        sound_study_max;
  logic [11:0]        sound_quiet_max;
  logic signed [11:0] temp_high_tenths;
  logic [9:0]         humidity_high_tenths;
  logic [6:0]         match_threshold;
  logic [6:0]         ambiguity_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_bright_level   <= 12'd2000;
      light_dim_level      <= 12'd500;
      sound_study_max      <= 12'd1500;
      sound_quiet_max      <= 12'd800;
      temp_high_tenths     <= 12'sd300;
      humidity_high_tenths <= 10'd700;
      match_threshold      <= 7'd70;
      ambiguity_gap        <= 7'd10;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LIGHT_BRIGHT: light_bright_level   <= cfg_data;
        REG_LIGHT_DIM:    light_dim_level      <= cfg_data;
        REG_SOUND_STUDY:  sound_study_max      <= cfg_data;
        REG_SOUND_QUIET:  sound_quiet_max      <= cfg_data;
        REG_TEMP_HIGH:    temp_high_tenths     <= $signed(cfg_data);
        REG_HUM_HIGH:     humidity_high_tenths <= cfg_data[9:0];
        REG_MATCH_THR:    match_threshold      <= cfg_data[6:0];
        REG_AMBIG_GAP:    ambiguity_gap        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and flow control
  logic v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3     = !out_valid || !out_stall;
  assign rdy2     = !v3 || rdy3;
  assign rdy1     = !v2 || rdy2;
  assign rdy0     = !v1 || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0) v1 <= in_valid;
      if (rdy1) v2 <= v1;
      if (rdy2) v3 <= v2;
      if (rdy3) out_valid <= v3;
    end
  end

  // stage 1: rule compares
  logic [3:0] rv_next [NUM_SETS];
  logic [3:0] rm_next [NUM_SETS];
  logic       bright, quiet, comfy, dht_ok;
  logic       s1_custom_next, s1_none_next;

  always_comb begin
    bright = light_raw >= light_bright_level;
    quiet  = sound_raw <= sound_quiet_max;
    dht_ok = temp_ok && hum_ok;
    comfy  = (temp_tenths >= COMFY_TEMP_LO) && (temp_tenths <= COMFY_TEMP_HI) &&
             (hum_tenths >= COMFY_HUM_LO) && (hum_tenths <= COMFY_HUM_HI);

    rv_next[0] = {dht_ok, sound_ok, light_ok, motion_ok};
    rm_next[0] = {comfy, sound_raw <= sound_study_max, bright, motion_seen};
    rv_next[1] = {dht_ok, motion_ok, light_ok, sound_ok};
    rm_next[1] = {comfy, !motion_seen, light_raw <= light_dim_level, quiet};
    rv_next[2] = {1'b0, motion_ok, hum_ok, temp_ok};
    rm_next[2] = {1'b0, motion_seen, hum_tenths >= humidity_high_tenths,
                  temp_tenths >= temp_high_tenths};
    rv_next[3] = {1'b0, sound_ok, light_ok, motion_ok};
    rm_next[3] = {1'b0, quiet, bright, !motion_seen};

    s1_custom_next = selected_mode == MODE_CUSTOM;
    s1_none_next   = !(light_ok || sound_ok || temp_ok || hum_ok || motion_ok);
  end

  logic [3:0] s1_rv [NUM_SETS];
  logic [3:0] s1_rm [NUM_SETS];
  logic       s1_custom, s1_none;

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      s1_rv     <= rv_next;
      s1_rm     <= rm_next;
      s1_custom <= s1_custom_next;
      s1_none   <= s1_none_next;
    end
  end

  // stage 2: weight sums, percent lookup, eligibility
  logic [3:0] val_sum [NUM_SETS];
  logic [3:0] mt_sum  [NUM_SETS];
  logic [3:0] vu      [NUM_SETS];
  logic [6:0] cov_next [NUM_SETS];
  logic [6:0] mat_next [NUM_SETS];
  logic [3:0] sup_next [NUM_SETS];
  logic [3:0] opp_next [NUM_SETS];
  logic [3:0] abs_next [NUM_SETS];
  logic [NUM_SETS-1:0] elig_next;

  always_comb begin
    for (int s = 0; s < NUM_SETS; s++) begin
      vu[s]      = s1_rv[s] & RULE_USED[s];
      val_sum[s] = '0;
      mt_sum[s]  = '0;
      for (int r = 0; r < NUM_RULES; r++) begin
        if (vu[s][r]) begin
          val_sum[s] = val_sum[s] + {1'b0, RULE_W[s][r]};
          if (s1_rm[s][r]) mt_sum[s] = mt_sum[s] + {1'b0, RULE_W[s][r]};
        end
      end
      sup_next[s]  = vu[s] & s1_rm[s];
      opp_next[s]  = vu[s] & ~s1_rm[s];
      abs_next[s]  = RULE_USED[s] & ~s1_rv[s];
      cov_next[s]  = PCT_TAB[{val_sum[s], SET_TOTAL[s]}];
      mat_next[s]  = PCT_TAB[{mt_sum[s], val_sum[s]}];
      elig_next[s] = ((abs_next[s] & RULE_REQ[s]) == 4'b0000) &&
                     (cov_next[s] >= MIN_COVERAGE);
    end
  end

  logic [6:0] s2_cov [NUM_SETS];
  logic [6:0] s2_mat [NUM_SETS];
  logic [3:0] s2_sup [NUM_SETS];
  logic [3:0] s2_opp [NUM_SETS];
  logic [3:0] s2_abs [NUM_SETS];
  logic [NUM_SETS-1:0] s2_elig;
  logic       s2_custom, s2_none;

  always_ff @(posedge clk) begin
    if (rdy1 && v1) begin
      s2_cov    <= cov_next;
      s2_mat    <= mat_next;
      s2_sup    <= sup_next;
      s2_opp    <= opp_next;
      s2_abs    <= abs_next;
      s2_elig   <= elig_next;
      s2_custom <= s1_custom;
      s2_none   <= s1_none;
    end
  end

  // stage 3: pick best eligible set, runner-up and fallback set
  logic [1:0] bm, best, second, sel;
  logic       found, has_second;
  logic [6:0] gap_next;

  always_comb begin
    bm         = 2'd0;
    best       = 2'd0;
    second     = 2'd0;
    found      = 1'b0;
    has_second = 1'b0;
    for (int i = 0; i < NUM_SETS; i++) begin
      if (s2_cov[i] > s2_cov[bm] ||
          (s2_cov[i] == s2_cov[bm] && s2_mat[i] > s2_mat[bm])) begin
        bm = 2'(i);
      end
      if (s2_elig[i]) begin
        if (!found || s2_mat[i] > s2_mat[best]) begin
          second     = best;
          has_second = found;
          best       = 2'(i);
          found      = 1'b1;
        end else if (!has_second || s2_mat[i] > s2_mat[second]) begin
          second     = 2'(i);
          has_second = 1'b1;
        end
      end
    end
    sel      = found ? best : bm;
    // can wrap when there is no runner-up; the verdict uses it only with has_second
    gap_next = s2_mat[best] - s2_mat[second];
  end

  logic       s3_custom, s3_none, s3_found, s3_has_second;
  logic [6:0] s3_gap, s3_cov, s3_mat;
  logic [3:0] s3_sup, s3_opp, s3_abs;
  logic [1:0] s3_sel;

  always_ff @(posedge clk) begin
    if (rdy2 && v2) begin
      s3_custom     <= s2_custom;
      s3_none       <= s2_none;
      s3_found      <= found;
      s3_has_second <= has_second;
      s3_gap        <= gap_next;
      s3_sel        <= sel;
      s3_cov        <= s2_cov[sel];
      s3_mat        <= s2_mat[sel];
      s3_sup        <= s2_sup[sel];
      s3_opp        <= s2_opp[sel];
      s3_abs        <= s2_abs[sel];
    end
  end

  // stage 4: verdict and output register
  logic [2:0] candidate_next;
  logic [1:0] verdict_next;
  logic [6:0] coverage_next, match_next;
  logic [3:0] support_next, oppose_next;
  logic [4:0] absent_next;

  always_comb begin
    candidate_next = 3'(s3_sel) + 3'd1;
    coverage_next  = s3_cov;
    match_next     = s3_mat;
    support_next   = s3_sup;
    oppose_next    = s3_opp;
    absent_next    = {1'b0, s3_abs};
    if (!s3_found) begin
      verdict_next = VERDICT_MISSING;
    end else if (s3_mat < match_threshold) begin
      verdict_next = VERDICT_UNKNOWN;
    end else if (s3_has_second && s3_gap < ambiguity_gap) begin
      verdict_next = VERDICT_AMBIGUOUS;
    end else begin
      verdict_next = VERDICT_POSSIBLE;
    end
    // fixed answers for custom mode and for no sensor at all
    if (s3_custom || s3_none) begin
      candidate_next = s3_custom ? MODE_CUSTOM : MODE_DETECT;
      verdict_next   = s3_custom ? VERDICT_MISSING : VERDICT_UNKNOWN;
      coverage_next  = '0;
      match_next     = '0;
      support_next   = '0;
      oppose_next    = '0;
      absent_next    = ABSENT_ALL;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v3) begin
      candidate    <= candidate_next;
      verdict      <= verdict_next;
      coverage_pct <= coverage_next;
      match_pct    <= match_next;
      support_bits <= support_next;
      oppose_bits  <= oppose_next;
      absent_bits  <= absent_next;
    end
  end

  // a rule is never both supporting and opposing
  a_sup_opp_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (support_bits & oppose_bits) == 4'b0000)
    else $error("support and oppose bits overlap");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (coverage_pct <= 7'd100 && match_pct <= 7'd100))
    else $error("percent out of range");

  // full coverage means no rule evidence is absent
  a_cov_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && coverage_pct == 7'd100 |-> absent_bits == 5'b00000)
    else $error("full coverage with absent evidence");

  // a stalled stage keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy3 |=> v3 && $stable(s3_sel) && $stable(s3_mat))
    else $error("stage 3 lost its item under stall");

  a_custom_fixed: assert property (@(posedge clk) disable iff (rst)
    out_valid && candidate == MODE_CUSTOM |->
      verdict == VERDICT_MISSING && absent_bits == ABSENT_ALL)
    else $error("custom mode result not fixed");

endmodule
